// File: src/nta_pkg.sv
// Package for the neighbor table ageing block: sizes, command and event codes,
// and the queued word type. No dependencies.
`default_nettype none
package nta_pkg;

	localparam int ENTRIES = 8;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int QDEPTH = 2;

	typedef logic [IW-1:0] idx_t;

	typedef enum logic [1:0] {
		CMD_ADV   = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_PURGE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		EV_REFRESH    = 4'd0,
		EV_INSERT     = 4'd1,
		EV_UPDATE     = 4'd2,
		EV_DELETE     = 4'd3,
		EV_MISS       = 4'd4,
		EV_DROP       = 4'd5,
		EV_AGED       = 4'd6,
		EV_PURGE      = 4'd7,
		EV_TICK_DONE  = 4'd8,
		EV_PURGE_DONE = 4'd9
	} ev_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] key;
		logic [63:0] dig;
		logic [4:0]  port;
		logic [15:0] ttl;
		logic [31:0] now;
	} item_t;

endpackage
`default_nettype wire

// File: src/nta_ifs.sv
// Valid/ready channel interfaces for the neighbor table ageing block.
// Standalone; no package needed.
`default_nettype none
interface nta_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] msap_key;
	logic [63:0] info_digest;
	logic [4:0]  rx_port;
	logic [15:0] ttl;
	logic [31:0] now_time;
	modport source (output valid, cmd, msap_key, info_digest, rx_port, ttl, now_time,
		input ready);
	modport sink (input valid, cmd, msap_key, info_digest, rx_port, ttl, now_time,
		output ready);
endinterface

interface nta_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic        changed;
	logic [3:0]  slot;
	logic [4:0]  entry_port;
	logic [31:0] remote_index;
	logic        too_many;
	logic [31:0] insert_count;
	logic [31:0] delete_count;
	logic [31:0] drop_count;
	logic [31:0] ageout_count;
	logic [31:0] change_time;
	logic        last;
	modport source (output valid, event_res, changed, slot, entry_port, remote_index,
		too_many, insert_count, delete_count, drop_count, ageout_count, change_time, last,
		input ready);
	modport sink (input valid, event_res, changed, slot, entry_port, remote_index,
		too_many, insert_count, delete_count, drop_count, ageout_count, change_time, last,
		output ready);
endinterface
`default_nettype wire

// File: src/nta_queue.sv
// Short command queue between front and back of the neighbor table.
// Depends on nta_pkg.
`default_nettype none
module nta_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  nta_pkg::item_t     wr_item,
	output logic               full,
	input  wire logic          pop,
	output nta_pkg::item_t     rd_item,
	output logic               nonempty
);
	import nta_pkg::*;

	item_t             slots_q [QDEPTH];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;

	assign full     = (cnt_q == 2'(QDEPTH));
	assign nonempty = (cnt_q != 2'd0);
	assign rd_item  = slots_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// File: src/nta_front.sv
// Front of the neighbor table: takes input words, drops the unused command,
// queues the rest. Depends on nta_pkg and nta_in_if.
`default_nettype none
module nta_front (
	nta_in_if.sink         req,
	output logic           push,
	output nta_pkg::item_t item,
	input  wire logic      full
);
	import nta_pkg::*;

	cmd_t cmd;

	assign cmd       = cmd_t'(req.cmd);
	assign req.ready = !full;
	// unused command code is accepted and discarded
	assign push      = req.valid && !full && (cmd != CMD_NONE);

	always_comb begin
		item.cmd  = cmd;
		item.key  = req.msap_key;
		item.dig  = req.info_digest;
		item.port = req.rx_port;
		item.ttl  = req.ttl;
		item.now  = req.now_time;
	end
endmodule
`default_nettype wire

// File: src/nta_back.sv
// Back of the neighbor table: walks it one slot per cycle unless rsp stalls,
// applies a command, drives the result register. Uses nta_pkg, nta_out_if.
`default_nettype none
module nta_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  nta_pkg::item_t rd_item,
	input  wire logic      nonempty,
	output logic           pop,
	nta_out_if.source      rsp
);
	import nta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_ADV  = 4'b0100,
		S_WALK = 4'b1000
	} state_t;

	state_t              state_q;
	logic                done_q;     // walk finished, closing word pending
	idx_t                idx_q;
	item_t               cur_q;
	logic                hit_q, free_found_q;
	idx_t                free_idx_q;

	logic [ENTRIES-1:0]  valid_q;
	logic [63:0]         key_q   [ENTRIES];
	logic [63:0]         dig_q   [ENTRIES];
	logic [4:0]          port_q  [ENTRIES];
	logic [15:0]         ttl_q   [ENTRIES];
	logic [31:0]         ridx_q  [ENTRIES];
	logic [31:0]         mark_q  [ENTRIES];

	logic                flag_q;
	logic [15:0]         timer_q;
	logic [31:0]         icnt_q, ins_q, del_q, drp_q, age_q, chg_q;

	logic                ov_q;

	// current slot read, one address
	logic                e_valid;
	logic [63:0]         e_key, e_dig;
	logic [4:0]          e_port;
	logic [15:0]         e_ttl;
	logic [31:0]         e_ridx;
	logic                out_free, is_last;

	// row and update decisions
	logic                emit, r_last, r_chg, r_flag;
	ev_t                 r_ev;
	logic [3:0]          r_slot;
	logic [4:0]          r_port;
	logic [31:0]         r_ridx;
	logic                inc_ins, inc_del, inc_drp, inc_age, set_chg;
	logic                adv_go, walk_go, expire;
	logic [31:0]         new_ridx;

	assign e_valid  = valid_q[idx_q];
	assign e_key    = key_q[idx_q];
	assign e_dig    = dig_q[idx_q];
	assign e_port   = port_q[idx_q];
	assign e_ttl    = ttl_q[idx_q];
	assign e_ridx   = ridx_q[idx_q];
	assign out_free = !ov_q || rsp.ready;
	assign is_last  = (idx_q == idx_t'(ENTRIES - 1));
	assign pop      = (state_q == S_IDLE) && nonempty;
	assign new_ridx = icnt_q + 32'd1;

	assign adv_go  = (state_q == S_ADV) && out_free;
	assign expire  = (cur_q.cmd == CMD_TICK) ? (e_valid && e_ttl == 16'd1)
		: (e_valid && e_port == cur_q.port);
	assign walk_go = (state_q == S_WALK) && (done_q ? out_free : (!expire || out_free));

	always_comb begin
		emit    = 1'b0;
		r_last  = 1'b0;
		r_chg   = 1'b0;
		r_ev    = EV_MISS;
		r_slot  = 4'd0;
		r_port  = 5'd0;
		r_ridx  = 32'd0;
		r_flag  = flag_q;
		inc_ins = 1'b0;
		inc_del = 1'b0;
		inc_drp = 1'b0;
		inc_age = 1'b0;
		set_chg = 1'b0;
		if (adv_go) begin
			emit   = 1'b1;
			r_last = 1'b1;
			priority if (cur_q.ttl == 16'd0) begin
				if (hit_q) begin
					r_ev    = EV_DELETE;
					r_slot  = 4'(idx_q);
					r_port  = e_port;
					r_ridx  = e_ridx;
					inc_del = 1'b1;
					set_chg = 1'b1;
				end
			end else if (hit_q) begin
				r_slot = 4'(idx_q);
				r_port = cur_q.port;
				r_ridx = e_ridx;
				if (e_port == cur_q.port && e_dig == cur_q.dig) begin
					r_ev = EV_REFRESH;
				end else begin
					r_ev    = EV_UPDATE;
					r_chg   = 1'b1;
					inc_ins = 1'b1;
					set_chg = 1'b1;
				end
			end else if (free_found_q) begin
				r_ev    = EV_INSERT;
				r_chg   = 1'b1;
				r_slot  = 4'(free_idx_q);
				r_port  = cur_q.port;
				r_ridx  = new_ridx;
				inc_ins = 1'b1;
				set_chg = 1'b1;
			end else begin
				r_ev    = EV_DROP;
				r_port  = cur_q.port;
				r_flag  = 1'b1;
				inc_drp = 1'b1;
			end
		end else if (walk_go) begin
			if (done_q) begin
				emit   = 1'b1;
				r_last = 1'b1;
				r_ev   = (cur_q.cmd == CMD_TICK) ? EV_TICK_DONE : EV_PURGE_DONE;
			end else if (expire) begin
				emit    = 1'b1;
				r_ev    = (cur_q.cmd == CMD_TICK) ? EV_AGED : EV_PURGE;
				r_slot  = 4'(idx_q);
				r_port  = e_port;
				r_ridx  = e_ridx;
				inc_del = 1'b1;
				inc_age = (cur_q.cmd == CMD_TICK);
				set_chg = 1'b1;
			end
		end
	end

	// table payload
	always_ff @(posedge clk) begin
		if (adv_go && cur_q.ttl != 16'd0) begin
			if (hit_q) begin
				ttl_q[idx_q] <= cur_q.ttl;
				if (r_ev == EV_UPDATE) begin
					dig_q[idx_q]  <= cur_q.dig;
					port_q[idx_q] <= cur_q.port;
					mark_q[idx_q] <= cur_q.now;
				end
			end else if (free_found_q) begin
				key_q[free_idx_q]  <= cur_q.key;
				dig_q[free_idx_q]  <= cur_q.dig;
				port_q[free_idx_q] <= cur_q.port;
				ttl_q[free_idx_q]  <= cur_q.ttl;
				mark_q[free_idx_q] <= cur_q.now;
				ridx_q[free_idx_q] <= new_ridx;
			end
		end
		if (walk_go && !done_q && cur_q.cmd == CMD_TICK && e_valid && e_ttl != 16'd0)
			ttl_q[idx_q] <= e_ttl - 16'd1;
		if (pop) cur_q <= rd_item;
		if (emit) begin
			rsp.event_res    <= r_ev;
			rsp.changed      <= r_chg;
			rsp.slot         <= r_slot;
			rsp.entry_port   <= r_port;
			rsp.remote_index <= r_ridx;
			rsp.too_many     <= r_flag;
			rsp.insert_count <= ins_q + 32'(inc_ins);
			rsp.delete_count <= del_q + 32'(inc_del);
			rsp.drop_count   <= drp_q + 32'(inc_drp);
			rsp.ageout_count <= age_q + 32'(inc_age);
			rsp.change_time  <= set_chg ? cur_q.now : chg_q;
			rsp.last         <= r_last;
		end
	end

	assign rsp.valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			flag_q       <= 1'b0;
			timer_q      <= 16'd0;
			icnt_q       <= 32'd0;
			ins_q        <= 32'd0;
			del_q        <= 32'd0;
			drp_q        <= 32'd0;
			age_q        <= 32'd0;
			chg_q        <= 32'd0;
			ov_q         <= 1'b0;
		end else begin
			if (emit)              ov_q <= 1'b1;
			else if (rsp.ready)    ov_q <= 1'b0;
			ins_q <= ins_q + 32'(inc_ins);
			del_q <= del_q + 32'(inc_del);
			drp_q <= drp_q + 32'(inc_drp);
			age_q <= age_q + 32'(inc_age);
			if (set_chg) chg_q <= cur_q.now;
			unique case (state_q)
				S_IDLE: begin
					if (nonempty) begin
						idx_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						done_q       <= 1'b0;
						if (rd_item.cmd == CMD_ADV) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_WALK;
							// flag after the tick is known up front
							if (rd_item.cmd == CMD_TICK && flag_q && timer_q != 16'd0) begin
								timer_q <= timer_q - 16'd1;
								if (timer_q == 16'd1) flag_q <= 1'b0;
							end
						end
					end
				end
				S_SCAN: begin
					if (e_valid && e_key == cur_q.key) begin
						hit_q   <= 1'b1;
						state_q <= S_ADV;
					end else begin
						if (!e_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= idx_q;
						end
						if (is_last) state_q <= S_ADV;
						else         idx_q   <= idx_q + idx_t'(1);
					end
				end
				S_ADV: begin
					if (adv_go) begin
						state_q <= S_IDLE;
						priority if (cur_q.ttl == 16'd0) begin
							if (hit_q) valid_q[idx_q] <= 1'b0;
						end else if (hit_q) begin
						end else if (free_found_q) begin
							valid_q[free_idx_q] <= 1'b1;
							icnt_q              <= new_ridx;
						end else begin
							flag_q <= 1'b1;
							if (cur_q.ttl > timer_q) timer_q <= cur_q.ttl;
						end
					end
				end
				S_WALK: begin
					if (walk_go) begin
						if (done_q) begin
							state_q <= S_IDLE;
						end else begin
							if (expire) valid_q[idx_q] <= 1'b0;
							if (is_last) done_q <= 1'b1;
							else         idx_q  <= idx_q + idx_t'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADV && !hit_q && !free_found_q) |-> (&valid_q))
		else $error("drop path with a free slot");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && r_ev == EV_INSERT) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("insert did not claim a slot");
	a_flag_timer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && flag_q) |-> (timer_q != 16'd0))
		else $error("overflow flag set with expired timer");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q <= idx_t'(ENTRIES - 1)))
		else $error("slot index out of range");
`endif
endmodule
`default_nettype wire

// File: src/neighbor_table_ageing_core.sv
// Top level of the neighbor table ageing block: front, queue and back.
// Depends on nta_pkg, nta_ifs, nta_front, nta_queue, nta_back.
//
// Usage:
//  req carries one command word: advertisement, one-second tick or port
//  purge. Command code 3 is accepted and produces nothing.
//  rsp carries result words; an advertisement gives one, a tick or purge
//  gives one per removed entry and a closing word; last marks the final one.
//  The front accepts words into a two-deep queue whenever it has room, so
//  req stays ready while the back is busy, until the queue is full.
//  Timing: the back walks the table one slot per cycle unless rsp holds up
//  a result. An advertisement is popped in idle, scans the slots up to the
//  match (at most ENTRIES) and ends in a result step; a tick or purge walks
//  all ENTRIES slots and ends in a closing step. The walk sets the rate.
//  The result sits in an output register; while rsp is stalled the back
//  holds before the next result-producing step and the queue keeps filling.
//  Reset clears every valid bit, counters, flag and timer at once; table
//  contents of free slots are never read.
`default_nettype none
module neighbor_table_ageing_core (
	input  wire logic clk,
	input  wire logic arst_n,
	nta_in_if.sink    req,
	nta_out_if.source rsp
);
	import nta_pkg::*;

	item_t wr_item, rd_item;
	logic  push, full, pop, nonempty;

	// classify and enqueue
	nta_front u_front (
		.req     (req),
		.push    (push),
		.item    (wr_item),
		.full    (full)
	);

	// decouples input acceptance from the table walk
	nta_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (wr_item),
		.full     (full),
		.pop      (pop),
		.rd_item  (rd_item),
		.nonempty (nonempty)
	);

	// table, counters and result register
	nta_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_item  (rd_item),
		.nonempty (nonempty),
		.pop      (pop),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire

// File: bench/nta_checker.sv
// Checker for the neighbor table ageing block: watches req and rsp, predicts
// result words from accepted command words and compares them. Needs nta_pkg, nta_ifs.
`default_nettype none
module nta_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	nta_in_if.sink    req,
	nta_out_if.sink   rsp,
	output int        errors,
	output int        pending
);
	import nta_pkg::*;

	typedef struct packed {
		ev_t         ev;
		logic        chg;
		logic [3:0]  slot;
		logic [4:0]  port;
		logic [31:0] ridx;
		logic        flag;
		logic [31:0] ins;
		logic [31:0] del;
		logic [31:0] drp;
		logic [31:0] age;
		logic [31:0] ctime;
		logic        last;
	} word_t;

	logic        t_valid [ENTRIES];
	logic [63:0] t_key   [ENTRIES];
	logic [63:0] t_dig   [ENTRIES];
	logic [4:0]  t_port  [ENTRIES];
	logic [15:0] t_ttl   [ENTRIES];
	logic [31:0] t_idx   [ENTRIES];
	logic        ovf_flag;
	logic [15:0] ovf_timer;
	logic [31:0] idx_ctr, n_ins, n_del, n_drp, n_age, chg_time;

	word_t due_words[$];
	assign pending = due_words.size();

	function automatic word_t mk(ev_t ev, logic chg, int slot, logic [4:0] port,
		logic [31:0] ridx);
		word_t w;
		w = '{ev, chg, slot[3:0], port, ridx, 1'b0, n_ins, n_del, n_drp, n_age,
			chg_time, 1'b0};
		return w;
	endfunction

	task automatic predict_table(input logic [1:0] cmd, input logic [63:0] key,
		input logic [63:0] dig, input logic [4:0] port, input logic [15:0] ttl,
		input logic [31:0] now);
		word_t batch[$];
		int hit;
		int fr;
		hit = -1;
		fr = -1;
		case (cmd)
			CMD_ADV: begin
				for (int i = 0; i < ENTRIES; i++)
					if (t_valid[i] && t_key[i] == key && hit < 0) hit = i;
				for (int i = 0; i < ENTRIES; i++)
					if (!t_valid[i] && fr < 0) fr = i;
				if (ttl == 0) begin
					if (hit >= 0) begin
						t_valid[hit] = 0; chg_time = now; n_del++;
						batch.push_back(mk(EV_DELETE, 0, hit, t_port[hit], t_idx[hit]));
					end else
						batch.push_back(mk(EV_MISS, 0, 0, 0, 0));
				end else if (hit >= 0) begin
					if (t_port[hit] == port && t_dig[hit] == dig) begin
						t_ttl[hit] = ttl;
						batch.push_back(mk(EV_REFRESH, 0, hit, port, t_idx[hit]));
					end else begin
						t_dig[hit] = dig; t_port[hit] = port; t_ttl[hit] = ttl;
						chg_time = now; n_ins++;
						batch.push_back(mk(EV_UPDATE, 1, hit, port, t_idx[hit]));
					end
				end else if (fr >= 0) begin
					t_valid[fr] = 1; t_key[fr] = key; t_dig[fr] = dig; t_port[fr] = port;
					t_ttl[fr] = ttl; chg_time = now; n_ins++;
					idx_ctr++; t_idx[fr] = idx_ctr;
					batch.push_back(mk(EV_INSERT, 1, fr, port, idx_ctr));
				end else begin
					ovf_flag = 1;
					if (ttl > ovf_timer) ovf_timer = ttl;
					n_drp++;
					batch.push_back(mk(EV_DROP, 0, 0, port, 0));
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < ENTRIES; i++)
					if (t_valid[i] && t_ttl[i] > 0) begin
						t_ttl[i]--;
						if (t_ttl[i] == 0) begin
							t_valid[i] = 0; chg_time = now; n_del++; n_age++;
							batch.push_back(mk(EV_AGED, 0, i, t_port[i], t_idx[i]));
						end
					end
				if (ovf_flag && ovf_timer > 0) begin
					ovf_timer--;
					if (ovf_timer == 0) ovf_flag = 0;
				end
				batch.push_back(mk(EV_TICK_DONE, 0, 0, 0, 0));
			end
			CMD_PURGE: begin
				for (int i = 0; i < ENTRIES; i++)
					if (t_valid[i] && t_port[i] == port) begin
						t_valid[i] = 0; chg_time = now; n_del++;
						batch.push_back(mk(EV_PURGE, 0, i, t_port[i], t_idx[i]));
					end
				batch.push_back(mk(EV_PURGE_DONE, 0, 0, 0, 0));
			end
			default: ;
		endcase
		foreach (batch[k]) begin
			batch[k].flag = ovf_flag;
			batch[k].last = (k == batch.size() - 1);
			due_words.push_back(batch[k]);
		end
	endtask

	task automatic cmp(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t w;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) t_valid[i] = 0;
			ovf_flag = 0; ovf_timer = 0; idx_ctr = 0;
			n_ins = 0; n_del = 0; n_drp = 0; n_age = 0; chg_time = 0;
			due_words.delete();
			errors = 0;
		end else begin
			if (req.valid && req.ready)
				predict_table(req.cmd, req.msap_key, req.info_digest, req.rx_port,
					req.ttl, req.now_time);
			if (rsp.valid && rsp.ready) begin
				if (due_words.size() == 0) begin
					$error("unexpected result word, event %0d", rsp.event_res);
					errors++;
				end else begin
					w = due_words.pop_front();
					cmp("event_res", w.ev, rsp.event_res);
					cmp("changed", w.chg, rsp.changed);
					cmp("slot", w.slot, rsp.slot);
					cmp("entry_port", w.port, rsp.entry_port);
					cmp("remote_index", w.ridx, rsp.remote_index);
					cmp("too_many", w.flag, rsp.too_many);
					cmp("insert_count", w.ins, rsp.insert_count);
					cmp("delete_count", w.del, rsp.delete_count);
					cmp("drop_count", w.drp, rsp.drop_count);
					cmp("ageout_count", w.age, rsp.ageout_count);
					cmp("change_time", w.ctime, rsp.change_time);
					cmp("last", w.last, rsp.last);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: bench/neighbor_table_ageing_core_tb.sv
// Testbench top for neighbor_table_ageing_core: drives command words, stalls
// the result side, gives the verdict. Needs nta_pkg, nta_ifs, nta_checker.
`default_nettype none
module neighbor_table_ageing_core_tb;
	import nta_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending;
	int   cycle = 0;
	logic hold_rsp = 0;   // long receiver hold-off, set by stimulus
	logic [31:0] uptime = 0;

	nta_in_if  req ();
	nta_out_if rsp ();

	always #2 clk = ~clk;

	neighbor_table_ageing_core u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	nta_checker u_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending));

	// Small key pool so that refresh, update, delete and table-full all hit often.
	logic [63:0] key_pool [12];
	logic [63:0] dig_pool [3];

	// Cycle limit: about 270 words, each with its busy walk and up to 9 stalled
	// results, plus a long hold-off, taken many times over.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: own stall pattern, plus a forced hold-off from stimulus.
	always @(posedge clk) begin
		int mode;
		mode = (cycle / 300) % 3;
		if (hold_rsp)
			rsp.ready <= 0;
		else if (mode == 0)
			rsp.ready <= 1;
		else if (mode == 1)
			rsp.ready <= ($urandom_range(0, 3) != 0);
		else
			rsp.ready <= ($urandom_range(0, 3) == 0);
	end

	// Present one word and hold it until accepted.
	task automatic send(input cmd_t c, input logic [63:0] k, input logic [63:0] d,
		input logic [4:0] p, input logic [15:0] t);
		uptime = uptime + $urandom_range(1, 5);
		req.valid    <= 1;
		req.cmd      <= c;
		req.msap_key <= k;
		req.info_digest <= d;
		req.rx_port  <= p;
		req.ttl      <= t;
		req.now_time <= ($urandom_range(0, 9) == 0) ? $urandom() : uptime;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic gap();
		req.valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic rand_word();
		int r;
		logic [15:0] t;
		r = $urandom_range(0, 99);
		t = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
		if (r < 65)
			send(CMD_ADV, key_pool[4'($urandom_range(0, 11))],
				dig_pool[2'($urandom_range(0, 2))], 5'($urandom_range(0, 3)), t);
		else if (r < 85)
			send(CMD_TICK, 64'($urandom()), 64'($urandom()), 5'($urandom()),
				16'($urandom()));
		else if (r < 95)
			send(CMD_PURGE, 64'($urandom()), 64'($urandom()), 5'($urandom_range(0, 3)),
				16'($urandom()));
		else if (r < 97)
			send(CMD_NONE, {$urandom(), $urandom()}, {$urandom(), $urandom()},
				5'($urandom()), 16'($urandom()));
		else
			send(CMD_ADV, {$urandom(), $urandom()}, {$urandom(), $urandom()},
				5'($urandom()), 16'($urandom()));
	endtask

	initial begin
		int burst;
		req.valid = 0; req.cmd = CMD_NONE; req.msap_key = 0; req.info_digest = 0;
		req.rx_port = 0; req.ttl = 0; req.now_time = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++) key_pool[4'(i)] = {$urandom(), $urandom()};
		dig_pool[0] = '0;
		dig_pool[1] = '1;
		dig_pool[2] = {$urandom(), $urandom()};

		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: miss, inserts up to full, refresh, update, drop, delete,
		// tick with ageing, purges, unused command.
		send(CMD_ADV, key_pool[0], dig_pool[0], 5'd0, 16'd0);
		for (int i = 0; i < ENTRIES; i++)
			send(CMD_ADV, key_pool[4'(i)], dig_pool[2'(i % 2)],
				(i % 2 != 0) ? 5'd31 : 5'd0, (i == 0) ? 16'd1 : 16'hFFFF);
		send(CMD_ADV, key_pool[1], dig_pool[1], 5'd31, 16'hFFFF);  // refresh
		send(CMD_ADV, key_pool[1], dig_pool[2], 5'd31, 16'd3);     // update
		send(CMD_ADV, key_pool[8], dig_pool[0], 5'd5, 16'd2);      // dropped
		send(CMD_ADV, key_pool[9], dig_pool[1], 5'd31, 16'hFFFF);  // dropped, max timer
		send(CMD_TICK, '1, '1, '1, '1);                            // slot 0 ages
		send(CMD_ADV, key_pool[2], dig_pool[0], 5'd0, 16'd0);      // delete
		send(CMD_PURGE, '0, '0, 5'd31, 16'd0);
		send(CMD_PURGE, '1, '1, 5'd0, '1);
		send(CMD_NONE, '1, '1, '1, '1);
		send(CMD_TICK, '0, '0, '0, '0);
		req.valid <= 0;

		// Sender pause until drained.
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		// Long receiver hold-off while the sender keeps offering.
		hold_rsp = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_rsp = 0;
			end
			for (int n = 0; n < 12; n++) rand_word();
		join
		req.valid <= 0;

		// Random bursts with gaps.
		for (int n = 0; n < 240; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				rand_word();
				n++;
			end
			if ($urandom_range(0, 2) != 0) gap();
			if (n % 80 < 12) begin
				req.valid <= 0;
				while (pending != 0) @(posedge clk);
			end
		end
		req.valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
src/nta_pkg.sv
src/nta_ifs.sv
src/nta_queue.sv
src/nta_front.sv
src/nta_back.sv
src/neighbor_table_ageing_core.sv
bench/nta_checker.sv
bench/neighbor_table_ageing_core_tb.sv
